FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define THD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define THD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/thd_pkg.sv
// ----------------------------------------------------------------------------
// thd_pkg
// shared types, constants and crc function of the measurement frame decoder
// ----------------------------------------------------------------------------
`default_nettype none

package thd_pkg;

  localparam logic [7:0]  CRC_POLY    = 8'h31;
  localparam logic [7:0]  CRC_INIT    = 8'hFF;
  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUMID_SCALE = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [16:0] FULL_SCALE  = 17'd65535;

  typedef enum logic [2:0] {
    POS_TEMP_MSB  = 3'd0,
    POS_TEMP_LSB  = 3'd1,
    POS_TEMP_CRC  = 3'd2,
    POS_HUMID_MSB = 3'd3,
    POS_HUMID_LSB = 3'd4,
    POS_HUMID_CRC = 3'd5
  } pos_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TEMP_CRC  = 2'd1,
    ST_HUMID_CRC = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [15:0]   temp_raw;
    logic [15:0]   humid_raw;
    frame_status_t status;
  } thd_frame_t;

  // crc-8, msb first, one byte
  function automatic logic [7:0] thd_crc8(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/thd_conv.sv
// ----------------------------------------------------------------------------
// thd_conv
// converts raw words to hundredths: scale product stage, then floor divide
// by 65535 with one correction step into the result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module thd_conv import thd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               req_valid,
  output logic                    req_ready,
  input  wire thd_frame_t         req,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [14:0]      out_temp_centi,
  output logic        [13:0]      out_humid_centi,
  output logic        [15:0]      out_temp_raw,
  output logic        [15:0]      out_humid_raw,
  output logic        [1:0]       out_frame_status
);

  logic        p_valid_r;
  logic [30:0] p_temp_prod_r;
  logic [29:0] p_humid_prod_r;
  thd_frame_t  p_frame_r;

  logic        out_valid_r;
  logic [14:0] out_temp_r;
  logic [13:0] out_humid_r;
  thd_frame_t  out_frame_r;

  logic        o_free;
  logic        p_free;

  logic [14:0] t_q;
  logic [16:0] t_rem;
  logic [14:0] t_floor;
  logic [13:0] h_q;
  logic [16:0] h_rem;
  logic [13:0] h_floor;
  logic [14:0] temp_nxt;
  logic [13:0] humid_nxt;

  assign o_free    = !out_valid_r || out_ready;
  assign p_free    = !p_valid_r || o_free;
  assign req_ready = p_free;

  // x = q*65536 + lo = q*65535 + (q + lo), and q + lo < 2*65535
  always_comb begin
    t_q     = p_temp_prod_r[30:16];
    t_rem   = {1'b0, p_temp_prod_r[15:0]} + {2'b00, t_q};
    t_floor = t_q + ((t_rem >= FULL_SCALE) ? 15'd1 : 15'd0);
    h_q     = p_humid_prod_r[29:16];
    h_rem   = {1'b0, p_humid_prod_r[15:0]} + {3'b000, h_q};
    h_floor = h_q + ((h_rem >= FULL_SCALE) ? 14'd1 : 14'd0);
    if (p_frame_r.status == ST_OK) begin
      temp_nxt  = t_floor - TEMP_OFFSET;
      humid_nxt = h_floor;
    end else begin
      temp_nxt  = '0;
      humid_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (p_free) begin
        p_valid_r <= req_valid;
      end
      if (o_free) begin
        out_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (p_free && req_valid) begin
      p_temp_prod_r  <= 31'(TEMP_SCALE) * 31'(req.temp_raw);
      p_humid_prod_r <= 30'(HUMID_SCALE) * 30'(req.humid_raw);
      p_frame_r      <= req;
    end
    if (o_free && p_valid_r) begin
      out_temp_r  <= temp_nxt;
      out_humid_r <= humid_nxt;
      out_frame_r <= p_frame_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_temp_centi   = $signed(out_temp_r);
  assign out_humid_centi  = out_humid_r;
  assign out_temp_raw     = out_frame_r.temp_raw;
  assign out_humid_raw    = out_frame_r.humid_raw;
  assign out_frame_status = out_frame_r.status;

  `THD_ASSERT_NOW(a_bad_crc_zero, out_valid_r && out_frame_r.status != ST_OK,
                  out_temp_r == '0 && out_humid_r == '0)
  `THD_ASSERT_NOW(a_humid_range, out_valid_r, out_humid_r <= HUMID_SCALE)
  `THD_ASSERT_NEXT(a_stage_moves, p_valid_r && o_free, out_valid_r)

endmodule

`default_nettype wire

FILE: rtl/core/temp_humid_frame_decoder.sv
// ----------------------------------------------------------------------------
// temp_humid_frame_decoder
// byte-wise frame parser with crc-8 checks and conversion to hundredths
// ----------------------------------------------------------------------------
// path: sixth frame byte -> s1 register -> product stage -> result register
// throughput: one byte per cycle while in_ready holds, set by the byte-wide crc step
// reset: synchronous rst_n clears position, words and all valid flags, crc to 0xff
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module temp_humid_frame_decoder import thd_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_rx_byte,
  input  wire logic          in_frame_start,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic signed [14:0] out_temp_centi,
  output logic        [13:0] out_humid_centi,
  output logic        [15:0] out_temp_raw,
  output logic        [15:0] out_humid_raw,
  output logic        [1:0]  out_frame_status
);

  pos_t        pos_r;
  pos_t        pos_nxt;
  pos_t        pos_eff;
  logic [7:0]  crc_r;
  logic [7:0]  crc_nxt;
  logic [7:0]  crc_in;
  logic [7:0]  crc_step;
  logic [15:0] temp_word_r;
  logic [15:0] temp_word_nxt;
  logic [15:0] humid_word_r;
  logic [15:0] humid_word_nxt;
  logic        temp_good_r;
  logic        temp_good_nxt;
  logic        frame_done;
  thd_frame_t  frame_nxt;

  logic        s1_valid_r;
  thd_frame_t  s1_frame_r;
  logic        s1_free;
  logic        conv_ready;
  logic        in_accept;

  assign s1_free   = !s1_valid_r || conv_ready;
  assign in_ready  = s1_free;
  assign in_accept = in_valid && in_ready;

  always_comb begin
    if (in_frame_start || pos_r > POS_HUMID_CRC) begin
      pos_eff = POS_TEMP_MSB;
    end else begin
      pos_eff = pos_r;
    end
    if (pos_eff == POS_TEMP_MSB || pos_eff == POS_HUMID_MSB) begin
      crc_in = CRC_INIT;
    end else begin
      crc_in = crc_r;
    end
    crc_step = thd_crc8(crc_in, in_rx_byte);
  end

  always_comb begin
    pos_nxt        = pos_r;
    crc_nxt        = crc_r;
    temp_word_nxt  = temp_word_r;
    humid_word_nxt = humid_word_r;
    temp_good_nxt  = temp_good_r;
    frame_done     = 1'b0;
    frame_nxt      = '{temp_raw: temp_word_r, humid_raw: humid_word_r, status: ST_OK};
    case (pos_eff)
      POS_TEMP_MSB: begin
        temp_word_nxt = {in_rx_byte, 8'h00};
        crc_nxt       = crc_step;
        pos_nxt       = POS_TEMP_LSB;
      end
      POS_TEMP_LSB: begin
        temp_word_nxt = {temp_word_r[15:8], in_rx_byte};
        crc_nxt       = crc_step;
        pos_nxt       = POS_TEMP_CRC;
      end
      POS_TEMP_CRC: begin
        temp_good_nxt = (in_rx_byte == crc_r);
        crc_nxt       = CRC_INIT;
        pos_nxt       = POS_HUMID_MSB;
      end
      POS_HUMID_MSB: begin
        humid_word_nxt = {in_rx_byte, 8'h00};
        crc_nxt        = crc_step;
        pos_nxt        = POS_HUMID_LSB;
      end
      POS_HUMID_LSB: begin
        humid_word_nxt = {humid_word_r[15:8], in_rx_byte};
        crc_nxt        = crc_step;
        pos_nxt        = POS_HUMID_CRC;
      end
      POS_HUMID_CRC: begin
        crc_nxt    = CRC_INIT;
        pos_nxt    = POS_TEMP_MSB;
        frame_done = 1'b1;
        if (!temp_good_r) begin
          frame_nxt.status = ST_TEMP_CRC;
        end else if (in_rx_byte != crc_r) begin
          frame_nxt.status = ST_HUMID_CRC;
        end else begin
          frame_nxt.status = ST_OK;
        end
      end
      default: begin
        pos_nxt = POS_TEMP_MSB;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= POS_TEMP_MSB;
      crc_r        <= CRC_INIT;
      temp_word_r  <= '0;
      humid_word_r <= '0;
      temp_good_r  <= 1'b0;
      s1_valid_r   <= 1'b0;
    end else begin
      if (in_accept) begin
        pos_r        <= pos_nxt;
        crc_r        <= crc_nxt;
        temp_word_r  <= temp_word_nxt;
        humid_word_r <= humid_word_nxt;
        temp_good_r  <= temp_good_nxt;
      end
      if (s1_free) begin
        s1_valid_r <= in_accept && frame_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && frame_done) begin
      s1_frame_r <= frame_nxt;
    end
  end

  thd_conv u_conv (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (s1_valid_r),
    .req_ready        (conv_ready),
    .req              (s1_frame_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_temp_centi   (out_temp_centi),
    .out_humid_centi  (out_humid_centi),
    .out_temp_raw     (out_temp_raw),
    .out_humid_raw    (out_humid_raw),
    .out_frame_status (out_frame_status)
  );

  `THD_ASSERT_NOW(a_pos_legal, 1'b1, pos_r <= POS_HUMID_CRC)
  `THD_ASSERT_NEXT(a_frame_request, in_accept && pos_eff == POS_HUMID_CRC, s1_valid_r)
  `THD_ASSERT_NEXT(a_start_realign, in_accept && in_frame_start, pos_r == POS_TEMP_LSB)

endmodule

`default_nettype wire
